// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/kdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlp_pkg
// Widths, codes and types shared by the key qualifier.
// ----------------------------------------------------------------------------
package kdlp_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int CFG_WIDTH    = 16;
   localparam int CMP_WIDTH    = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int ACTION_WIDTH = 2;
   localparam int STATE_WIDTH  = 3;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // actions
   localparam logic [ACTION_WIDTH-1:0] ACT_INIT = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_TICK = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_READ = 2'd2;

   // key states
   localparam logic [STATE_WIDTH-1:0] MODE_IDLE     = 3'd0;
   localparam logic [STATE_WIDTH-1:0] MODE_PRESSED  = 3'd1;
   localparam logic [STATE_WIDTH-1:0] MODE_HELD     = 3'd2;
   localparam logic [STATE_WIDTH-1:0] MODE_LONG     = 3'd3;
   localparam logic [STATE_WIDTH-1:0] MODE_RELEASED = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG     = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACTIVE   = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd25;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd500;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] settle_limit;
      logic [CFG_WIDTH-1:0] long_limit;
      logic                 press_level;
   } cfg_type;

endpackage

// ----- design/kdlp_if.sv -----
// ----------------------------------------------------------------------------
// kdlp_if
// Valid/ready channels of the key qualifier: request, response, csr write.
// ----------------------------------------------------------------------------
interface kdlp_req_if;
   logic                              valid;
   logic                              ready;
   logic [kdlp_pkg::ACTION_WIDTH-1:0] action;
   logic                              pin_level;

   modport source (output valid, output action, output pin_level, input ready);
   modport sink   (input valid, input action, input pin_level, output ready);
endinterface

interface kdlp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [kdlp_pkg::STATE_WIDTH-1:0] key_state;

   modport source (output valid, output key_state, input ready);
   modport sink   (input valid, input key_state, output ready);
endinterface

interface kdlp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kdlp_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [kdlp_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/key_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Debounced key qualifier with pressed, held, long press and released states.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per action: init (loads pin_level as the settled
//   level), tick (one debounce sample of pin_level) or read (returns the
//   state, then clears pressed to held and released to idle).
//   rsp returns one key_state word for every request word, in order.
//   csr writes the settle limit (index 0), the long-press limit (index 1)
//   and the press level (index 2); write only while no request is in flight.
//   A request word passes the input register, then the state update into
//   the response register. Throughput: one word per clock while rsp.ready
//   holds; the state update is one compare and 16-bit saturating
//   increment per counter between the two registers.
//   Reset: state idle, settled level 0, counters 0, thresholds 25 and 500,
//   active level 0. A stalled response holds; the input register keeps one
//   more word, then req.ready drops until rsp.ready returns.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_debounce_long_press (
   input  logic      clock,
   input  logic      reset,
   kdlp_req_if.sink  req_if,
   kdlp_rsp_if.source rsp_if,
   kdlp_csr_if.sink  csr_if
);

   kdlp_pkg::cfg_type cfg_ff;

   logic                              in_valid_ff;
   logic [kdlp_pkg::ACTION_WIDTH-1:0] in_action_ff;
   logic                              in_level_ff;

   logic                              out_valid_ff;
   logic [kdlp_pkg::STATE_WIDTH-1:0]  out_state_ff;

   logic                              out_free;
   logic                              advance;
   logic                              req_fire;
   logic [kdlp_pkg::STATE_WIDTH-1:0]  core_state;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_fire = req_if.valid && req_if.ready;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_limit <= kdlp_pkg::DEBOUNCE_RESET;
         cfg_ff.long_limit   <= kdlp_pkg::LONG_RESET;
         cfg_ff.press_level  <= 1'b0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            kdlp_pkg::CSR_DEBOUNCE: cfg_ff.settle_limit <=
               kdlp_pkg::CFG_WIDTH'(csr_if.data);
            kdlp_pkg::CSR_LONG: cfg_ff.long_limit <=
               kdlp_pkg::CFG_WIDTH'(csr_if.data);
            kdlp_pkg::CSR_ACTIVE: cfg_ff.press_level <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_if.action;
         in_level_ff  <= req_if.pin_level;
      end
   end

   kdlp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .action    (in_action_ff),
      .pin_level (in_level_ff),
      .cfg       (cfg_ff),
      .key_state (core_state)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff <= core_state;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.key_state = out_state_ff;

   `ASSERT_NEXT(a_in_hold, in_valid_ff && !out_free, in_valid_ff && $stable(in_action_ff),
      "buffered request word lost while response stalled")
   `ASSERT_NEXT(a_adv_rsp, advance, out_valid_ff, "processed word gave no response")
   `ASSERT_IMPL(a_state_range, out_valid_ff, out_state_ff <= kdlp_pkg::MODE_RELEASED,
      "response carries an undefined key state")

endmodule

// ----- design/kdlp_core.sv -----
// ----------------------------------------------------------------------------
// kdlp_core
// Key state and counters; each word updates them on step.
// ----------------------------------------------------------------------------
module kdlp_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [kdlp_pkg::ACTION_WIDTH-1:0] action,
   input  logic                              pin_level,
   input  kdlp_pkg::cfg_type                 cfg,
   output logic [kdlp_pkg::STATE_WIDTH-1:0]  key_state
);

   localparam logic [kdlp_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [kdlp_pkg::STATE_WIDTH-1:0] mode_ff, mode_in;
   logic                             level_ff, level_in;
   logic [kdlp_pkg::COUNT_WIDTH-1:0] db_count_ff, db_count_in;
   logic [kdlp_pkg::COUNT_WIDTH-1:0] hold_count_ff, hold_count_in;

   logic [kdlp_pkg::COUNT_WIDTH-1:0] db_inc, hold_inc;
   logic [kdlp_pkg::CMP_WIDTH-1:0]   db_inc_x, db_lim_x, hold_inc_x, hold_lim_x;
   logic [kdlp_pkg::STATE_WIDTH-1:0] mode_tick;

   assign db_inc   = (db_count_ff == COUNT_MAX) ? db_count_ff : db_count_ff + 1'b1;
   assign hold_inc = (hold_count_ff == COUNT_MAX) ? hold_count_ff : hold_count_ff + 1'b1;

   assign db_inc_x   = kdlp_pkg::CMP_WIDTH'(db_inc);
   assign db_lim_x   = kdlp_pkg::CMP_WIDTH'(cfg.settle_limit);
   assign hold_inc_x = kdlp_pkg::CMP_WIDTH'(hold_inc);
   assign hold_lim_x = kdlp_pkg::CMP_WIDTH'(cfg.long_limit);

   always_comb begin
      mode_in       = mode_ff;
      level_in      = level_ff;
      db_count_in   = db_count_ff;
      hold_count_in = hold_count_ff;
      mode_tick     = mode_ff;
      key_state     = mode_ff;
      unique case (action)
         kdlp_pkg::ACT_INIT: begin
            level_in      = pin_level;
            mode_in       = kdlp_pkg::MODE_IDLE;
            db_count_in   = '0;
            hold_count_in = '0;
            key_state     = kdlp_pkg::MODE_IDLE;
         end
         kdlp_pkg::ACT_TICK: begin
            if (pin_level != level_ff) begin
               db_count_in = db_inc;
               if (db_inc_x >= db_lim_x) begin
                  level_in    = pin_level;
                  db_count_in = '0;
                  if (pin_level == cfg.press_level) begin
                     mode_tick     = kdlp_pkg::MODE_PRESSED;
                     hold_count_in = '0;
                  end else if (mode_ff == kdlp_pkg::MODE_HELD ||
                               mode_ff == kdlp_pkg::MODE_LONG) begin
                     mode_tick = kdlp_pkg::MODE_RELEASED;
                  end else begin
                     mode_tick = kdlp_pkg::MODE_IDLE;
                  end
               end
            end else begin
               db_count_in = '0;
            end
            mode_in = mode_tick;
            // hold counter runs only if still held after the level check
            if (mode_tick == kdlp_pkg::MODE_HELD) begin
               hold_count_in = hold_inc;
               if (hold_inc_x >= hold_lim_x) begin
                  mode_in = kdlp_pkg::MODE_LONG;
               end
            end
            key_state = mode_in;
         end
         kdlp_pkg::ACT_READ: begin
            key_state = mode_ff;
            if (mode_ff == kdlp_pkg::MODE_PRESSED) begin
               mode_in = kdlp_pkg::MODE_HELD;
            end else if (mode_ff == kdlp_pkg::MODE_RELEASED) begin
               mode_in = kdlp_pkg::MODE_IDLE;
            end
         end
         default: begin
            key_state = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= kdlp_pkg::MODE_IDLE;
         level_ff      <= 1'b0;
         db_count_ff   <= '0;
         hold_count_ff <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         level_ff      <= level_in;
         db_count_ff   <= db_count_in;
         hold_count_ff <= hold_count_in;
      end
   end

endmodule
